// ----- src/lbp_pkg.sv -----
// ----------------------------------------------------------------------------
// lbp_pkg
// shared constants, types and the neighbour compare for the 3x3 lbp operator
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int PIX_W      = 8;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_W      = 11;
  localparam int IROW_W     = 11;
  localparam int CODE_W     = 8;
  localparam int LINE_W     = 2 * PIX_W;

  localparam logic [CFG_W-1:0]  WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0]  HEIGHT_RST = CFG_W'(480);
  localparam logic [IROW_W-1:0] IROW_MAX   = {IROW_W{1'b1}};

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } lbp_reg_t;

  // item kinds
  typedef enum logic [0:0] {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } lbp_cmd_t;

  typedef logic [PIX_W-1:0] pix_t;

  // 3x3 window, index = row * 3 + column, row 0 on top
  typedef pix_t [8:0] lbp_win_t;

  // which window columns and rows lie inside the image
  typedef struct packed {
    logic xl;
    logic xc;
    logic xr;
    logic yt;
    logic yc;
    logic yb;
  } lbp_bounds_t;

  // bit i set when neighbour i is inside the image and >= centre
  function automatic logic [CODE_W-1:0] lbp_code(input lbp_win_t win,
                                                  input lbp_bounds_t bnd);
    logic [CODE_W-1:0] code;
    pix_t              ctr;
    ctr     = win[4];
    code[0] = bnd.xl && bnd.yt && (win[0] >= ctr);  // top-left
    code[1] = bnd.xc && bnd.yt && (win[1] >= ctr);  // top
    code[2] = bnd.xr && bnd.yt && (win[2] >= ctr);  // top-right
    code[3] = bnd.xr && bnd.yc && (win[5] >= ctr);  // right
    code[4] = bnd.xr && bnd.yb && (win[8] >= ctr);  // bottom-right
    code[5] = bnd.xc && bnd.yb && (win[7] >= ctr);  // bottom
    code[6] = bnd.xl && bnd.yb && (win[6] >= ctr);  // bottom-left
    code[7] = bnd.xl && bnd.yc && (win[3] >= ctr);  // left
    return code;
  endfunction

endpackage

// ----- src/lbp_ram.sv -----
// ----------------------------------------------------------------------------
// lbp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/lbp_win.sv -----
// ----------------------------------------------------------------------------
// lbp_win
// 3x3 pixel window: shifts one column per item and forms the pattern code
// ----------------------------------------------------------------------------
module lbp_win (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        shift_en,
  input  lbp_pkg::pix_t               up_pix,
  input  lbp_pkg::pix_t               mid_pix,
  input  lbp_pkg::pix_t               new_pix,
  input  lbp_pkg::lbp_bounds_t        bnd,
  output logic [lbp_pkg::CODE_W-1:0]  code
);
  import lbp_pkg::*;

  lbp_win_t win_r;
  lbp_win_t win_nxt;

  always_comb begin
    win_nxt = win_r;
    if (shift_en) begin
      for (int k = 0; k < 3; k++) begin
        win_nxt[k*3+0] = win_r[k*3+1];
        win_nxt[k*3+1] = win_r[k*3+2];
      end
      win_nxt[2] = up_pix;
      win_nxt[5] = mid_pix;
      win_nxt[8] = new_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

  assign code = lbp_code(win_r, bnd);

endmodule

// ----- src/lbp_image_operator_unit.sv -----
// ----------------------------------------------------------------------------
// lbp_image_operator_unit
// streaming 3x3 local binary pattern operator over 8-bit grayscale frames
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): one pixel per transaction in raster
//   order, in_cmd selects pixel or flush. after a frame's width*height pixels
//   the producer sends width+1 flush transactions to drain the last row.
//   output channel (out_valid / out_stall): one code per pixel, bit 0 for the
//   top-left neighbour, out_frame_last marks the frame's final code.
//   configuration: cfg_we writes cfg_data into register cfg_index (image
//   width, image height) while no transaction is in flight.
// throughput and pipeline
//   one transaction per clock, sustained while out_stall does not hold the pipe. a code
//   is registered after the transaction that completes its lower-right neighbour
//   through the line ram read, window update and code register. the two line
//   stores share one 16-bit wide ram, read once and written once per transaction.
// stalls
//   the whole pipe advances when the output register is empty or being taken,
//   so in_stall follows out_valid && out_stall in the same cycle.
// reset
//   synchronous, active low. counters and window clear, width 640, height 480.
//   the line ram is not cleared; its stale entries only feed neighbours that
//   lie outside the image.
// ----------------------------------------------------------------------------
module lbp_image_operator_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // input transactions
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_cmd,
  input  logic [lbp_pkg::PIX_W-1:0]    in_pixel,
  // result transactions
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lbp_pkg::CODE_W-1:0]   out_lbp_code,
  output logic                         out_frame_last,
  // configuration writes
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [lbp_pkg::CFG_W-1:0]    cfg_data
);
  import lbp_pkg::*;

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic [CFG_W-1:0] eff_w;
  logic [CFG_W-1:0] eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (lbp_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (width_r == '0) begin
      eff_w = CFG_W'(1);
    end else if (width_r > CFG_W'(MAX_WIDTH)) begin
      eff_w = CFG_W'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (height_r == '0) begin
      eff_h = CFG_W'(1);
    end else if (height_r > CFG_W'(MAX_HEIGHT)) begin
      eff_h = CFG_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  // ---------------------------------------------------------------- flow
  logic out_valid_r;
  logic advance;
  logic in_acc;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;
  assign in_acc   = in_valid && advance;

  // ---------------------------------------------------------------- counters
  logic [COL_W-1:0]  icol_r, icol_nxt;
  logic [IROW_W-1:0] irow_r, irow_nxt;
  logic [COL_W-1:0]  ocol_r, ocol_nxt;
  logic [ROW_W-1:0]  orow_r, orow_nxt;

  logic              emit;
  logic              in_wrap;
  logic              last_col;
  logic              last_pix;
  logic [CFG_W-1:0]  ocol_x;
  logic [CFG_W-1:0]  orow_x;
  lbp_bounds_t       bnd;
  pix_t              in_v;

  assign in_v     = (lbp_cmd_t'(in_cmd) == CMD_FLUSH) ? '0 : in_pixel;
  assign emit     = (irow_r >= IROW_W'(2)) || (irow_r == IROW_W'(1) && icol_r != '0);
  assign in_wrap  = (CFG_W'(icol_r) + CFG_W'(1)) >= eff_w;
  assign ocol_x   = CFG_W'(ocol_r);
  assign orow_x   = CFG_W'(orow_r);
  assign last_col = (ocol_x + CFG_W'(1)) >= eff_w;
  assign last_pix = last_col && ((orow_x + CFG_W'(1)) >= eff_h);

  // neighbour columns and rows that fall inside the image
  always_comb begin
    bnd.xl = (ocol_r != '0) && (ocol_x <= eff_w);
    bnd.xc = ocol_x < eff_w;
    bnd.xr = (ocol_x + CFG_W'(1)) < eff_w;
    bnd.yt = (orow_r != '0) && (orow_x <= eff_h);
    bnd.yc = orow_x < eff_h;
    bnd.yb = (orow_x + CFG_W'(1)) < eff_h;
  end

  always_comb begin
    icol_nxt = icol_r;
    irow_nxt = irow_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (in_acc) begin
      if (in_wrap) begin
        icol_nxt = '0;
        if (irow_r != IROW_MAX) begin
          irow_nxt = irow_r + IROW_W'(1);
        end
      end else begin
        icol_nxt = icol_r + COL_W'(1);
      end
      if (emit) begin
        if (last_pix) begin
          // frame done, start the next one
          icol_nxt = '0;
          irow_nxt = '0;
          ocol_nxt = '0;
          orow_nxt = '0;
        end else if (last_col) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + ROW_W'(1);
        end else begin
          ocol_nxt = ocol_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icol_r <= '0;
      irow_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
    end else begin
      icol_r <= icol_nxt;
      irow_r <= irow_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
    end
  end

  // ---------------------------------------------------------------- line ram
  // one entry per column holds {upper row, middle row}
  logic              ram_we;
  logic [LINE_W-1:0] ram_wdata;
  logic [LINE_W-1:0] ram_rdata;

  // stage 1: ram data back, read-modify-write of the column entry
  logic              s1_vld_r;
  logic              s1_emit_r;
  logic              s1_last_r;
  lbp_bounds_t       s1_bnd_r;
  pix_t              s1_v_r;
  logic [COL_W-1:0]  s1_addr_r;
  logic              s1_fwd_r;
  logic [LINE_W-1:0] s1_fwd_data_r;
  logic [LINE_W-1:0] s1_line;
  logic              fwd_hit;

  lbp_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (ram_wdata),
    .re    (advance),
    .raddr (icol_r),
    .rdata (ram_rdata)
  );

  // the write of the item leaving stage 1 lands on the edge that reads the
  // next item; same column (narrow images) means the read saw stale data
  assign fwd_hit   = s1_vld_r && (s1_addr_r == icol_r);
  assign s1_line   = s1_fwd_r ? s1_fwd_data_r : ram_rdata;
  assign ram_we    = advance && s1_vld_r;
  assign ram_wdata = {s1_line[PIX_W-1:0], s1_v_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_emit_r     <= emit;
      s1_last_r     <= last_pix;
      s1_bnd_r      <= bnd;
      s1_v_r        <= in_v;
      s1_addr_r     <= icol_r;
      s1_fwd_r      <= fwd_hit;
      s1_fwd_data_r <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------- window
  logic              s2_vld_r;
  logic              s2_last_r;
  lbp_bounds_t       s2_bnd_r;
  logic [CODE_W-1:0] code;

  lbp_win u_win (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (ram_we),
    .up_pix   (s1_line[LINE_W-1:PIX_W]),
    .mid_pix  (s1_line[PIX_W-1:0]),
    .new_pix  (s1_v_r),
    .bnd      (s2_bnd_r),
    .code     (code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (advance) begin
      s2_vld_r <= s1_vld_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_last_r <= s1_last_r;
      s2_bnd_r  <= s1_bnd_r;
    end
  end

  // ---------------------------------------------------------------- output
  logic [CODE_W-1:0] out_code_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_vld_r) begin
      out_code_r <= code;
      out_last_r <= s2_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_lbp_code   = out_code_r;
  assign out_frame_last = out_last_r;

  // ---------------------------------------------------------------- checks
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit && last_pix) |=>
      (icol_r == '0 && irow_r == '0 && ocol_r == '0 && orow_r == '0))
    else $error("counters not cleared after the frame's last code");

  a_emit_reaches_window: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_vld_r && s1_emit_r) |=> s2_vld_r)
    else $error("emitting transaction lost between ram and window stage");

  a_ocol_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit && !last_col) |=> (ocol_r == $past(ocol_r) + COL_W'(1)))
    else $error("output column did not advance");

  a_no_emit_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    (irow_r == '0) |-> !emit)
    else $error("code requested before the second row started");

endmodule
